// ----- rtl/core/tmtw_pkg.sv -----
// Shared command codes and character constants for the text-mode terminal writer.
// No dependencies.
package tmtw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR   = 3'd0,
    CMD_SET_ATTR   = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_INIT       = 3'd3,
    CMD_WRITE_CELL = 3'd4,
    CMD_READ_CELL  = 3'd5
  } cmd_e;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;

endpackage

// ----- rtl/core/tmtw_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/text_mode_terminal_writer.sv -----
// Text-mode terminal writer top level: command FSM, cursor state and screen RAM.
// Depends on tmtw_pkg and tmtw_ram.
//
// Usage: each request on the slave stream carries one command in tuser and its
// operands in tdata; each request produces exactly one response on the master
// stream with the read data, the cursor position after the command and a scroll
// flag. One request is worked on at a time; tready is high only when the FSM is
// idle, while a finished response can still sit in the output register.
// Set-attribute, a plain tab, an unused command and an out-of-range cell access
// touch no RAM; newline and a wrapping tab only move to the next row; a character,
// backspace or cell write writes one cell (a character that wraps the line then
// moves to the next row) and a cell read reads one. A scroll writes a blank to
// each cell of the freed row, one RAM write per cell; clear and initialize write
// every cell through the single write port of the screen RAM.
// Scrolling moves a row offset instead of copying cells.
// Reset: cursor home, attribute 0x07, then a fill pass writes a blank cell to every
// cell of the screen (SCREEN_WIDTH * SCREEN_HEIGHT cells, 2000 by default); no request
// is taken and no response is sent during it.
// Stall: a response waits in the output register until taken; the FSM holds its
// final state until the register is free.
module text_mode_terminal_writer #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // char_code[7:0], attribute[15:8], cell_row[20:16],
                                       // cell_col[27:21], zero[31:28]
  input  logic [2:0]  s_axis_tuser_i,  // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // cell_value[15:0], cursor_row[20:16],
                                       // cursor_col[27:21], scrolled[28], zero[31:29]
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int MW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int XW    = CW + 2;

  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_HEIGHT - 1);
  localparam logic [MW-1:0] LAST_MOD  = MW'((SCREEN_WIDTH - 1) % TAB_STOP);
  localparam logic [MW-1:0] TOP_MOD   = MW'(TAB_STOP - 1);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_EXEC, S_PHYS, S_ADDR, S_WR, S_RD, S_RDW, S_NEXT, S_ROWFILL, S_RESP
  } state_e;

  typedef enum logic [1:0] {OP_WR, OP_RD, OP_ROW} op_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [7:0]       ch_q, ch_d;
  logic [7:0]       attr_in_q, attr_in_d;
  logic [4:0]       crow_q, crow_d;
  logic [6:0]       ccol_q, ccol_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic [MW-1:0]    mod_q, mod_d;
  logic [RW-1:0]    base_q, base_d;
  logic [7:0]       cur_attr_q, cur_attr_d;
  logic [RW-1:0]    tr_q, tr_d;
  logic [CW-1:0]    tc_q, tc_d;
  logic [RW-1:0]    phys_q, phys_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [15:0]      wdata_q, wdata_d;
  logic             nl_pend_q, nl_pend_d;
  logic             resp_q, resp_d;
  logic             scrolled_q, scrolled_d;
  logic [15:0]      value_q, value_d;
  logic             m_valid_q, m_valid_d;
  logic [31:0]      m_data_q, m_data_d;

  logic             in_range;
  logic [CW:0]      col_inc;
  logic [XW-1:0]    col_tab;
  logic [RW:0]      row_inc;
  logic [RW:0]      phys_sum;
  logic             ram_we;
  logic             ram_re;
  logic [15:0]      ram_rdata;

  tmtw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(addr_q),
    .wr_data_i(wdata_q),
    .rd_en_i  (ram_re),
    .rd_addr_i(addr_q),
    .rd_data_o(ram_rdata)
  );

  assign ram_we = (state_q == S_WR) || (state_q == S_FILL) || (state_q == S_ROWFILL);
  assign ram_re = (state_q == S_RD);

  assign in_range = (32'(crow_q) < SCREEN_HEIGHT) && (32'(ccol_q) < SCREEN_WIDTH);
  assign col_inc  = (CW + 1)'(col_q) + (CW + 1)'(1);
  assign col_tab  = XW'(col_q) + XW'(TAB_STOP) - XW'(mod_q);
  assign row_inc  = (RW + 1)'(row_q) + (RW + 1)'(1);
  assign phys_sum = (RW + 1)'(tr_q) + (RW + 1)'(base_q);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_d      = cmd_q;
    ch_d       = ch_q;
    attr_in_d  = attr_in_q;
    crow_d     = crow_q;
    ccol_d     = ccol_q;
    row_d      = row_q;
    col_d      = col_q;
    mod_d      = mod_q;
    base_d     = base_q;
    cur_attr_d = cur_attr_q;
    tr_d       = tr_q;
    tc_d       = tc_q;
    phys_d     = phys_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    wdata_d    = wdata_q;
    nl_pend_d  = nl_pend_q;
    resp_d     = resp_q;
    scrolled_d = scrolled_q;
    value_d    = value_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_FILL: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_ADDR) begin
          state_d = resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d      = s_axis_tuser_i;
          ch_d       = s_axis_tdata_i[7:0];
          attr_in_d  = s_axis_tdata_i[15:8];
          crow_d     = s_axis_tdata_i[20:16];
          ccol_d     = s_axis_tdata_i[27:21];
          value_d    = '0;
          scrolled_d = 1'b0;
          nl_pend_d  = 1'b0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        unique case (cmd_q) inside
          tmtw_pkg::CMD_PUT_CHAR: begin
            op_d    = OP_WR;
            wdata_d = {cur_attr_q, tmtw_pkg::CH_SPACE};
            if (ch_q == tmtw_pkg::CH_NEWLINE) begin
              col_d   = '0;
              mod_d   = '0;
              state_d = S_NEXT;
            end else if (ch_q == tmtw_pkg::CH_BACKSPACE) begin
              tr_d = row_q;
              tc_d = col_q;
              if (col_q != '0) begin
                col_d = col_q - CW'(1);
                tc_d  = col_q - CW'(1);
                mod_d = (mod_q == '0) ? TOP_MOD : mod_q - MW'(1);
              end else if (row_q != '0) begin
                row_d = row_q - RW'(1);
                tr_d  = row_q - RW'(1);
                col_d = LAST_COL;
                tc_d  = LAST_COL;
                mod_d = LAST_MOD;
              end
              state_d = S_PHYS;
            end else if (ch_q == tmtw_pkg::CH_TAB) begin
              if (32'(col_tab) >= SCREEN_WIDTH) begin
                col_d   = '0;
                mod_d   = '0;
                state_d = S_NEXT;
              end else begin
                col_d = CW'(col_tab);
                mod_d = '0;
              end
            end else begin
              tr_d    = row_q;
              tc_d    = col_q;
              wdata_d = {cur_attr_q, ch_q};
              if (32'(col_inc) >= SCREEN_WIDTH) begin
                col_d     = '0;
                mod_d     = '0;
                nl_pend_d = 1'b1;
              end else begin
                col_d = CW'(col_inc);
                mod_d = (mod_q == TOP_MOD) ? '0 : mod_q + MW'(1);
              end
              state_d = S_PHYS;
            end
          end
          tmtw_pkg::CMD_SET_ATTR: begin
            cur_attr_d = attr_in_q;
          end
          tmtw_pkg::CMD_CLEAR, tmtw_pkg::CMD_INIT: begin
            row_d  = '0;
            col_d  = '0;
            mod_d  = '0;
            base_d = '0;
            addr_d = '0;
            resp_d = 1'b1;
            if (cmd_q == tmtw_pkg::CMD_INIT || cur_attr_q == '0) begin
              cur_attr_d = tmtw_pkg::DEFAULT_ATTR;
              wdata_d    = {tmtw_pkg::DEFAULT_ATTR, tmtw_pkg::CH_SPACE};
            end else begin
              wdata_d = {cur_attr_q, tmtw_pkg::CH_SPACE};
            end
            state_d = S_FILL;
          end
          tmtw_pkg::CMD_WRITE_CELL: begin
            if (in_range) begin
              op_d    = OP_WR;
              tr_d    = RW'(crow_q);
              tc_d    = CW'(ccol_q);
              wdata_d = {attr_in_q, ch_q};
              state_d = S_PHYS;
            end
          end
          tmtw_pkg::CMD_READ_CELL: begin
            if (in_range) begin
              op_d    = OP_RD;
              tr_d    = RW'(crow_q);
              tc_d    = CW'(ccol_q);
              state_d = S_PHYS;
            end
          end
          default: begin
          end
        endcase
      end
      S_PHYS: begin
        phys_d  = (32'(phys_sum) >= SCREEN_HEIGHT) ?
                  RW'(phys_sum - (RW + 1)'(SCREEN_HEIGHT)) : RW'(phys_sum);
        state_d = S_ADDR;
      end
      S_ADDR: begin
        addr_d = AW'(32'(phys_q) * SCREEN_WIDTH + 32'(tc_q));
        unique case (op_q)
          OP_WR:   state_d = S_WR;
          OP_RD:   state_d = S_RD;
          OP_ROW:  state_d = S_ROWFILL;
          default: state_d = S_RESP;
        endcase
      end
      S_WR: begin
        state_d = nl_pend_q ? S_NEXT : S_RESP;
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        value_d = ram_rdata;
        state_d = S_RESP;
      end
      S_NEXT: begin
        nl_pend_d = 1'b0;
        if (32'(row_inc) >= SCREEN_HEIGHT) begin
          row_d      = LAST_ROW;
          scrolled_d = 1'b1;
          phys_d     = base_q;
          tc_d       = '0;
          cnt_d      = '0;
          base_d     = (base_q == LAST_ROW) ? '0 : base_q + RW'(1);
          wdata_d    = {cur_attr_q, tmtw_pkg::CH_SPACE};
          op_d       = OP_ROW;
          state_d    = S_ADDR;
        end else begin
          row_d   = RW'(row_inc);
          state_d = S_RESP;
        end
      end
      S_ROWFILL: begin
        addr_d = addr_q + AW'(1);
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == LAST_COL) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, scrolled_q, 7'(col_q), 5'(row_q), value_q};
          resp_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_FILL;
      op_q       <= OP_WR;
      cmd_q      <= '0;
      ch_q       <= '0;
      attr_in_q  <= '0;
      crow_q     <= '0;
      ccol_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      mod_q      <= '0;
      base_q     <= '0;
      cur_attr_q <= tmtw_pkg::DEFAULT_ATTR;
      tr_q       <= '0;
      tc_q       <= '0;
      phys_q     <= '0;
      addr_q     <= '0;
      cnt_q      <= '0;
      wdata_q    <= {tmtw_pkg::DEFAULT_ATTR, tmtw_pkg::CH_SPACE};
      nl_pend_q  <= 1'b0;
      resp_q     <= 1'b0;
      scrolled_q <= 1'b0;
      value_q    <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      cmd_q      <= cmd_d;
      ch_q       <= ch_d;
      attr_in_q  <= attr_in_d;
      crow_q     <= crow_d;
      ccol_q     <= ccol_d;
      row_q      <= row_d;
      col_q      <= col_d;
      mod_q      <= mod_d;
      base_q     <= base_d;
      cur_attr_q <= cur_attr_d;
      tr_q       <= tr_d;
      tc_q       <= tc_d;
      phys_q     <= phys_d;
      addr_q     <= addr_d;
      cnt_q      <= cnt_d;
      wdata_q    <= wdata_d;
      nl_pend_q  <= nl_pend_d;
      resp_q     <= resp_d;
      scrolled_q <= scrolled_d;
      value_q    <= value_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
    end
  end

endmodule
